// File: src/i2c_master_byte_writer_core_assert.svh
// Assertion macros shared by the I2C byte writer modules
`ifndef I2C_MASTER_BYTE_WRITER_CORE_ASSERT_SVH
`define I2C_MASTER_BYTE_WRITER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define I2CMBW_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define I2CMBW_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define I2CMBW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define I2CMBW_ASSERT(lbl, clk, rst, prop)
`define I2CMBW_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define I2CMBW_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: src/i2cmbw_pkg.sv
// Types and constants of the I2C byte writer
package i2cmbw_pkg;

   localparam int HalfPeriodBits = 10;
   localparam logic [HalfPeriodBits-1:0] HalfPeriodReset = 10'd5;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_START = 2'd1,
      ACT_STOP  = 2'd2,
      ACT_WRITE = 2'd3
   } action_type;

   typedef enum logic [7:0] {
      PH_IDLE     = 8'b0000_0001,
      PH_START_A  = 8'b0000_0010,
      PH_START_B  = 8'b0000_0100,
      PH_STOP_A   = 8'b0000_1000,
      PH_STOP_B   = 8'b0001_0000,
      PH_STOP_C   = 8'b0010_0000,
      PH_BIT_LOW  = 8'b0100_0000,
      PH_BIT_HIGH = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
      logic       sda_in;
   } req_item_type;

   typedef struct packed {
      logic scl_out;
      logic sda_out;
      logic busy_res;
      logic ack_valid;
      logic ack_seen;
      logic rejected;
   } rsp_item_type;

endpackage

// File: src/i2cmbw_fsm.sv
// Bus sequencer: advances the I2C phase state by one tick per step
`include "i2c_master_byte_writer_core_assert.svh"

module i2cmbw_fsm #(
   parameter int TickCountBits = 10
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    step_en,
   input  i2cmbw_pkg::req_item_type                item,
   input  logic [i2cmbw_pkg::HalfPeriodBits-1:0]   half_period,
   output i2cmbw_pkg::rsp_item_type                result
);

   localparam int LimW = (TickCountBits > i2cmbw_pkg::HalfPeriodBits) ?
                         TickCountBits : i2cmbw_pkg::HalfPeriodBits;
   localparam logic [LimW-1:0] CountMax = LimW'((64'd1 << TickCountBits) - 64'd1);

   i2cmbw_pkg::phase_type       phase_ff, phase_in;
   logic [TickCountBits-1:0]    tick_ff, tick_in;
   logic [3:0]                  bit_ff, bit_in;
   logic [7:0]                  shift_ff, shift_in;
   logic                        scl_ff, scl_in;
   logic                        sda_ff, sda_in;
   logic [LimW-1:0]             lim_ext;
   logic [TickCountBits-1:0]    limit;
   logic [3:0]                  bit_next;
   logic                        rej, avalid, aseen;

   always_comb begin
      lim_ext = LimW'(half_period);
      if (lim_ext == '0) begin
         lim_ext = LimW'(1);
      end
      if (lim_ext > CountMax) begin
         lim_ext = CountMax;
      end
      limit = lim_ext[TickCountBits-1:0];
   end

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      rej      = 1'b0;
      avalid   = 1'b0;
      aseen    = 1'b0;
      bit_next = bit_ff + 4'd1;
      if (phase_ff == i2cmbw_pkg::PH_IDLE) begin
         case (i2cmbw_pkg::action_type'(item.action))
            i2cmbw_pkg::ACT_START: begin
               phase_in = i2cmbw_pkg::PH_START_A;
               tick_in  = TickCountBits'(1);
               scl_in   = 1'b1;
               sda_in   = 1'b0;
            end
            i2cmbw_pkg::ACT_STOP: begin
               phase_in = i2cmbw_pkg::PH_STOP_A;
               tick_in  = TickCountBits'(1);
               scl_in   = 1'b0;
               sda_in   = 1'b0;
            end
            i2cmbw_pkg::ACT_WRITE: begin
               phase_in = i2cmbw_pkg::PH_BIT_LOW;
               tick_in  = TickCountBits'(1);
               shift_in = item.data_byte;
               bit_in   = 4'd0;
               scl_in   = 1'b0;
               sda_in   = item.data_byte[7];
            end
            default: begin
            end
         endcase
      end else begin
         rej = (i2cmbw_pkg::action_type'(item.action) != i2cmbw_pkg::ACT_TICK);
         if (tick_ff < limit) begin
            tick_in = tick_ff + TickCountBits'(1);
         end else begin
            case (phase_ff)
               i2cmbw_pkg::PH_START_A: begin
                  phase_in = i2cmbw_pkg::PH_START_B;
                  tick_in  = TickCountBits'(1);
                  scl_in   = 1'b0;
                  sda_in   = 1'b0;
               end
               i2cmbw_pkg::PH_START_B: begin
                  phase_in = i2cmbw_pkg::PH_IDLE;
                  tick_in  = '0;
                  scl_in   = 1'b0;
                  sda_in   = 1'b0;
               end
               i2cmbw_pkg::PH_STOP_A: begin
                  phase_in = i2cmbw_pkg::PH_STOP_B;
                  tick_in  = TickCountBits'(1);
                  scl_in   = 1'b1;
                  sda_in   = 1'b0;
               end
               i2cmbw_pkg::PH_STOP_B: begin
                  phase_in = i2cmbw_pkg::PH_STOP_C;
                  tick_in  = TickCountBits'(1);
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
               end
               i2cmbw_pkg::PH_STOP_C: begin
                  phase_in = i2cmbw_pkg::PH_IDLE;
                  tick_in  = '0;
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
               end
               i2cmbw_pkg::PH_BIT_LOW: begin
                  phase_in = i2cmbw_pkg::PH_BIT_HIGH;
                  tick_in  = TickCountBits'(1);
                  scl_in   = 1'b1;
                  sda_in   = bit_ff[3] | shift_ff[7];
               end
               i2cmbw_pkg::PH_BIT_HIGH: begin
                  if (bit_ff[3]) begin
                     avalid   = 1'b1;
                     aseen    = ~item.sda_in;
                     bit_in   = 4'd0;
                     phase_in = i2cmbw_pkg::PH_IDLE;
                     tick_in  = '0;
                     scl_in   = 1'b0;
                     sda_in   = 1'b1;
                  end else begin
                     shift_in = {shift_ff[6:0], 1'b1};
                     bit_in   = bit_next;
                     phase_in = i2cmbw_pkg::PH_BIT_LOW;
                     tick_in  = TickCountBits'(1);
                     scl_in   = 1'b0;
                     sda_in   = bit_next[3] | shift_ff[6];
                  end
               end
               default: begin
                  phase_in = i2cmbw_pkg::PH_IDLE;
                  tick_in  = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= i2cmbw_pkg::PH_IDLE;
         tick_ff  <= '0;
         bit_ff   <= 4'd0;
         shift_ff <= 8'hFF;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
      end else if (step_en) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
      end
   end

   assign result.scl_out   = scl_in;
   assign result.sda_out   = sda_in;
   assign result.busy_res  = (phase_in != i2cmbw_pkg::PH_IDLE);
   assign result.ack_valid = avalid;
   assign result.ack_seen  = aseen;
   assign result.rejected  = rej;

   `I2CMBW_ASSERT_IMPLY(a_idle_count_zero, clock, reset,
      phase_ff == i2cmbw_pkg::PH_IDLE, tick_ff == '0)
   `I2CMBW_ASSERT_IMPLY(a_busy_count_nonzero, clock, reset,
      phase_ff != i2cmbw_pkg::PH_IDLE, tick_ff != '0)
   `I2CMBW_ASSERT_IMPLY(a_ack_only_at_end, clock, reset,
      result.ack_seen || result.ack_valid,
      result.ack_valid && phase_ff == i2cmbw_pkg::PH_BIT_HIGH && bit_ff[3])

endmodule

// File: src/i2c_master_byte_writer_core.sv
// Top level of the tick-driven I2C byte writer
//
//  port group  dir  handshake           carries
//  req_        in   valid / stall       one tick with optional command
//  rsp_        out  valid / stall       bus levels and status after the tick
//  csr_        in   valid / ready       half period in ticks
//
// One tick enters per clock while req_stall is low; its result passes through
// an input register, the sequencer step, then the result register.
// The path holds those two register stages; throughput is one tick
// per clock whenever rsp_stall is low.
// A stalled result holds the result register and then the input register;
// req_stall rises only when both are full.
// Reset idles the bus with both lines released and the half period at 5.
`include "i2c_master_byte_writer_core_assert.svh"

module i2c_master_byte_writer_core #(
   parameter int TickCountBits = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_action,
   input  logic [7:0] req_data_byte,
   input  logic       req_sda_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_scl_out,
   output logic       rsp_sda_out,
   output logic       rsp_busy_res,
   output logic       rsp_ack_valid,
   output logic       rsp_ack_seen,
   output logic       rsp_rejected,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [i2cmbw_pkg::HalfPeriodBits-1:0] csr_half_period_ticks
);

   logic                                    in_valid_ff, in_valid_in;
   i2cmbw_pkg::req_item_type                in_item_ff;
   logic                                    out_valid_ff, out_valid_in;
   i2cmbw_pkg::rsp_item_type                out_item_ff;
   i2cmbw_pkg::rsp_item_type                step_result;
   logic [i2cmbw_pkg::HalfPeriodBits-1:0]   half_ff;
   logic                                    out_free;
   logic                                    step_en;
   logic                                    req_take;

   assign out_free  = ~out_valid_ff | ~rsp_stall;
   assign step_en   = in_valid_ff & out_free;
   assign req_stall = in_valid_ff & ~out_free;
   assign req_take  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_take | (in_valid_ff & ~step_en);
   assign out_valid_in = step_en | (out_valid_ff & ~out_free);

   i2cmbw_fsm #(
      .TickCountBits(TickCountBits)
   ) u_fsm (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .item       (in_item_ff),
      .half_period(half_ff),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         half_ff      <= i2cmbw_pkg::HalfPeriodReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            half_ff <= csr_half_period_ticks;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.action    <= req_action;
         in_item_ff.data_byte <= req_data_byte;
         in_item_ff.sda_in    <= req_sda_in;
      end
      if (step_en) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_scl_out   = out_item_ff.scl_out;
   assign rsp_sda_out   = out_item_ff.sda_out;
   assign rsp_busy_res  = out_item_ff.busy_res;
   assign rsp_ack_valid = out_item_ff.ack_valid;
   assign rsp_ack_seen  = out_item_ff.ack_seen;
   assign rsp_rejected  = out_item_ff.rejected;

   `I2CMBW_ASSERT_IMPLY(a_stall_only_when_full, clock, reset,
      req_stall, in_valid_ff && out_valid_ff && rsp_stall)
   `I2CMBW_ASSERT_NEXT(a_step_fills_output, clock, reset,
      step_en, out_valid_ff)
   `I2CMBW_ASSERT_NEXT(a_held_input_kept, clock, reset,
      in_valid_ff && out_valid_ff && rsp_stall, in_valid_ff && $stable(in_item_ff))

endmodule
